// ===== rtl/icc_pkg.sv =====
// Shared types, character codes and lookup functions for the identifier case converter.
// Used by icc_step, icc_result_queue, identifier_case_converter, icc_checker and the testbench; no dependencies.

package icc_pkg;

    localparam int unsigned RESULTS_MAX = 4;
    localparam int unsigned COUNT_W     = $clog2(RESULTS_MAX + 1);
    localparam int unsigned SLOT_W      = $clog2(RESULTS_MAX);

    localparam logic [1:0] CLS_LOWER = 2'd0;
    localparam logic [1:0] CLS_UPPER = 2'd1;
    localparam logic [1:0] CLS_DIGIT = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    localparam logic [3:0] STY_CAMEL    = 4'd0;
    localparam logic [3:0] STY_PASCAL   = 4'd1;
    localparam logic [3:0] STY_SNAKE    = 4'd2;
    localparam logic [3:0] STY_KEBAB    = 4'd3;
    localparam logic [3:0] STY_CONSTANT = 4'd4;
    localparam logic [3:0] STY_DOT      = 4'd5;
    localparam logic [3:0] STY_CAPITAL  = 4'd6;
    localparam logic [3:0] STY_TRAIN    = 4'd7;
    localparam logic [3:0] STY_PATH     = 4'd8;
    localparam logic [3:0] STY_SENTENCE = 4'd9;
    localparam logic [3:0] STY_PLAIN    = 4'd10;

    localparam logic [1:0] XF_LOWER = 2'd0;
    localparam logic [1:0] XF_UPPER = 2'd1;
    localparam logic [1:0] XF_CAP   = 2'd2;

    localparam logic [6:0] CH_NONE       = 7'h00;
    localparam logic [6:0] CH_UNDERSCORE = 7'h5F;
    localparam logic [6:0] CH_DASH       = 7'h2D;
    localparam logic [6:0] CH_DOT        = 7'h2E;
    localparam logic [6:0] CH_SLASH      = 7'h2F;
    localparam logic [6:0] CH_SPACE      = 7'h20;
    localparam logic [6:0] CASE_DELTA    = 7'h20;

    typedef struct packed {
        logic       eos;
        logic       char_valid;
        logic [6:0] out_char;
    } t_result;

    typedef t_result [RESULTS_MAX-1:0] t_result_list;

    typedef struct packed {
        logic [6:0] held_char;
        logic       held_valid;
        logic       held_first;
        logic       in_word;
        logic       first_word;
        logic [1:0] prev_cls;
        logic [1:0] prev2_cls;
    } t_state;

    localparam t_state STATE_RESET = '{
        held_char:  7'd0,
        held_valid: 1'b0,
        held_first: 1'b0,
        in_word:    1'b0,
        first_word: 1'b1,
        prev_cls:   CLS_OTHER,
        prev2_cls:  CLS_OTHER
    };

    function automatic logic [1:0] classify(input logic [6:0] ch);
        logic [1:0] cls;
        if (ch >= 7'h61 && ch <= 7'h7A) begin
            cls = CLS_LOWER;
        end else if (ch >= 7'h41 && ch <= 7'h5A) begin
            cls = CLS_UPPER;
        end else if (ch >= 7'h30 && ch <= 7'h39) begin
            cls = CLS_DIGIT;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic logic [6:0] sep_char(input logic [3:0] st);
        logic [6:0] sep;
        unique case (st)
            STY_SNAKE, STY_CONSTANT:              sep = CH_UNDERSCORE;
            STY_KEBAB, STY_TRAIN:                 sep = CH_DASH;
            STY_DOT:                              sep = CH_DOT;
            STY_PATH:                             sep = CH_SLASH;
            STY_CAPITAL, STY_SENTENCE, STY_PLAIN: sep = CH_SPACE;
            default:                              sep = CH_NONE;
        endcase
        return sep;
    endfunction

    function automatic logic [1:0] word_xform(input logic [3:0] st, input logic word0);
        logic [1:0] xf;
        unique case (st)
            STY_CAMEL:                          xf = word0 ? XF_LOWER : XF_CAP;
            STY_PASCAL, STY_CAPITAL, STY_TRAIN: xf = XF_CAP;
            STY_CONSTANT:                       xf = XF_UPPER;
            STY_SENTENCE:                       xf = word0 ? XF_CAP : XF_LOWER;
            default:                            xf = XF_LOWER;
        endcase
        return xf;
    endfunction

endpackage

// ===== rtl/icc_step.sv =====
// Word splitting and case mapping for one input character: next stream state and result list.
// Depends on icc_pkg.

module icc_step (
    input  logic [3:0]           i_style,
    input  icc_pkg::t_state      i_state,
    input  logic [6:0]           i_char,
    input  logic                 i_last,
    output icc_pkg::t_state      o_state,
    output icc_pkg::t_result_list o_list,
    output logic [icc_pkg::COUNT_W-1:0] o_count
);

    typedef struct packed {
        logic       has_pre;
        logic [6:0] pre;
        logic [6:0] chr;
    } t_emit;

    function automatic t_emit emit(input logic [3:0] st, input logic [6:0] ch,
                                   input logic first, input logic fwa);
        t_emit      e;
        logic [1:0] cls;
        logic [6:0] sep;
        logic [1:0] xf;
        logic       up;
        cls = icc_pkg::classify(ch);
        sep = icc_pkg::sep_char(st);
        e.has_pre = 1'b0;
        e.pre     = icc_pkg::CH_NONE;
        if (first && !fwa) begin
            if (sep != icc_pkg::CH_NONE) begin
                e.has_pre = 1'b1;
                e.pre     = sep;
            end else if ((st == icc_pkg::STY_CAMEL || st == icc_pkg::STY_PASCAL) &&
                         cls == icc_pkg::CLS_DIGIT) begin
                e.has_pre = 1'b1;
                e.pre     = icc_pkg::CH_UNDERSCORE;
            end
        end
        xf = icc_pkg::word_xform(st, fwa);
        up = (xf == icc_pkg::XF_UPPER) || (xf == icc_pkg::XF_CAP && first);
        if (up && cls == icc_pkg::CLS_LOWER) begin
            e.chr = ch - icc_pkg::CASE_DELTA;
        end else if (!up && cls == icc_pkg::CLS_UPPER) begin
            e.chr = ch + icc_pkg::CASE_DELTA;
        end else begin
            e.chr = ch;
        end
        return e;
    endfunction

    logic [3:0]                  st;
    logic [1:0]                  cc;
    icc_pkg::t_state             s;
    logic                        e1_first;
    logic                        e1_fwa;
    logic                        first;
    t_emit                       e1;
    t_emit                       e2;
    logic                        e2_en;
    icc_pkg::t_result_list       list;
    logic [icc_pkg::COUNT_W-1:0] n;
    logic [icc_pkg::COUNT_W-1:0] n_m1;

    always_comb begin
        st = (i_style > icc_pkg::STY_PLAIN) ? icc_pkg::STY_PLAIN : i_style;
        cc = icc_pkg::classify(i_char);
        s  = i_state;

        e1_first = s.held_first;
        e1_fwa   = s.first_word;
        first    = 1'b0;

        if (cc == icc_pkg::CLS_OTHER) begin
            if (s.in_word) begin
                s.first_word = 1'b0;
            end
            s.in_word   = 1'b0;
            s.prev_cls  = icc_pkg::CLS_OTHER;
            s.prev2_cls = icc_pkg::CLS_OTHER;
        end else if (!s.in_word) begin
            s.in_word   = 1'b1;
            first       = 1'b1;
            s.prev2_cls = icc_pkg::CLS_OTHER;
            s.prev_cls  = cc;
        end else if (s.prev2_cls == icc_pkg::CLS_UPPER && s.prev_cls == icc_pkg::CLS_UPPER &&
                     cc == icc_pkg::CLS_LOWER) begin
            // held upper opens the new word
            s.first_word = 1'b0;
            e1_first     = 1'b1;
            e1_fwa       = 1'b0;
            s.prev2_cls  = icc_pkg::CLS_UPPER;
            s.prev_cls   = icc_pkg::CLS_LOWER;
        end else if ((s.prev_cls == icc_pkg::CLS_LOWER || s.prev_cls == icc_pkg::CLS_DIGIT) &&
                     cc == icc_pkg::CLS_UPPER) begin
            s.first_word = 1'b0;
            first        = 1'b1;
            s.prev2_cls  = icc_pkg::CLS_OTHER;
            s.prev_cls   = icc_pkg::CLS_UPPER;
        end else begin
            s.prev2_cls = s.prev_cls;
            s.prev_cls  = cc;
        end

        e1 = emit(st, s.held_char, e1_first, e1_fwa);
        e2 = emit(st, i_char, first, s.first_word);
        e2_en = i_last && (cc != icc_pkg::CLS_OTHER);

        s.held_valid = (cc != icc_pkg::CLS_OTHER);
        if (cc != icc_pkg::CLS_OTHER) begin
            s.held_char  = i_char;
            s.held_first = first;
        end

        list = '0;
        n    = '0;
        if (i_state.held_valid) begin
            if (e1.has_pre) begin
                list[n[icc_pkg::SLOT_W-1:0]] = '{eos: 1'b0, char_valid: 1'b1, out_char: e1.pre};
                n = n + 1'b1;
            end
            list[n[icc_pkg::SLOT_W-1:0]] = '{eos: 1'b0, char_valid: 1'b1, out_char: e1.chr};
            n = n + 1'b1;
        end
        if (e2_en) begin
            if (e2.has_pre) begin
                list[n[icc_pkg::SLOT_W-1:0]] = '{eos: 1'b0, char_valid: 1'b1, out_char: e2.pre};
                n = n + 1'b1;
            end
            list[n[icc_pkg::SLOT_W-1:0]] = '{eos: 1'b0, char_valid: 1'b1, out_char: e2.chr};
            n = n + 1'b1;
        end

        n_m1 = n - 1'b1;
        if (i_last) begin
            if (n == '0) begin
                list[0] = '{eos: 1'b1, char_valid: 1'b0, out_char: icc_pkg::CH_NONE};
                n       = icc_pkg::COUNT_W'(1);
            end else begin
                list[n_m1[icc_pkg::SLOT_W-1:0]].eos = 1'b1;
            end
            s = icc_pkg::STATE_RESET;
        end

        o_state = s;
        o_list  = list;
        o_count = n;
    end

endmodule

// ===== rtl/icc_result_queue.sv =====
// Result register holding the result list of one character, drained one transaction a cycle while i_ready is high.
// Depends on icc_pkg.

module icc_result_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  icc_pkg::t_result_list       i_list,
    input  logic [icc_pkg::COUNT_W-1:0] i_count,
    output logic                        o_free,
    output logic                        o_valid,
    input  logic                        i_ready,
    output icc_pkg::t_result            o_result,
    output logic [icc_pkg::COUNT_W-1:0] o_count
);

    icc_pkg::t_result_list       r_q;
    logic [icc_pkg::COUNT_W-1:0] r_cnt;
    logic [icc_pkg::SLOT_W-1:0]  r_rd;
    logic                        pop;

    assign o_valid  = (r_cnt != '0);
    assign pop      = o_valid && i_ready;
    assign o_free   = (r_cnt == '0) || ((r_cnt == 1'b1) && i_ready);
    assign o_result = r_q[r_rd];
    assign o_count  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
            r_rd  <= '0;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
            r_rd  <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_list;
        end
    end

endmodule

// ===== rtl/identifier_case_converter.sv =====
// Top level of the identifier case converter: input register, stream state, style register.
// Depends on icc_pkg, icc_step and icc_result_queue.
//
//   channel  | direction | accepted when                 | carries
//   s_axis   | in        | tvalid & tready               | character, end of string
//   m_axis   | out       | tvalid & tready               | character, char flag, end of string
//   cfg      | in        | valid & ready (always ready)  | case style
//
// A character is taken into the input register, then converted combinationally into a list
// of zero to four results loaded into the result register, which sends one per cycle while the
// receiver is ready. Sustained rate is one character per cycle while each produces at most
// one result; a character with more results holds the result register until its last one leaves.
// Synchronous active-low reset returns the stream state to the start of a string.
// Input stalls only while the input register is full and the result register still drains.

module identifier_case_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [6:0] in_char, [7] zero fill
    input  logic       i_s_axis_tlast,   // last_char
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [6:0] out_char, [7] zero fill
    output logic       o_m_axis_tuser,   // [0] char_valid
    output logic       o_m_axis_tlast,   // end_of_string
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    logic                        r_in_valid;
    logic [6:0]                  r_in_char;
    logic                        r_in_last;
    logic [3:0]                  r_style;
    icc_pkg::t_state             r_state;
    icc_pkg::t_state             n_state;
    icc_pkg::t_result_list       step_list;
    logic [icc_pkg::COUNT_W-1:0] step_count;
    logic [icc_pkg::COUNT_W-1:0] q_count;
    icc_pkg::t_result            q_result;
    logic                        q_free;
    logic                        load;
    logic                        in_accept;

    assign load            = r_in_valid && q_free;
    assign o_s_axis_tready = !r_in_valid || load;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    icc_step u_step (
        .i_style (r_style),
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_list  (step_list),
        .o_count (step_count)
    );

    icc_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_list   (step_list),
        .i_count  (step_count),
        .o_free   (q_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (q_result),
        .o_count  (q_count)
    );

    assign o_m_axis_tdata = {1'b0, q_result.out_char};
    assign o_m_axis_tuser = q_result.char_valid;
    assign o_m_axis_tlast = q_result.eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_style    <= icc_pkg::STY_CAMEL;
            r_state    <= icc_pkg::STATE_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_style <= i_cfg_data;
            end
            if (load) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_s_axis_tdata[6:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= icc_pkg::COUNT_W'(icc_pkg::RESULTS_MAX))
        else $error("result count above list size");

    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser || o_m_axis_tlast))
        else $error("result carries neither a character nor an end marker");

    a_eos_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (q_count == 1'b1))
        else $error("end marker not on the final result of the list");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_last) |=> (!r_state.held_valid && !r_state.in_word &&
                                 r_state.first_word))
        else $error("stream state not cleared after end of string");
`endif

endmodule

// ===== verif/icc_checker.sv =====
// Checker for the identifier case converter: watches the character, result and style channels,
// predicts the converted stream and compares every result. Depends on icc_pkg.

module icc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [6:0] in_char, [7] zero fill
    input  logic       i_s_tlast,    // last_char
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [6:0] out_char, [7] zero fill
    input  logic       i_m_tuser,    // [0] char_valid
    input  logic       i_m_tlast,    // end_of_string
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [3:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    icc_pkg::t_result expected_chars[$];
    logic [3:0] style_reg;
    logic [6:0] held_ch;
    logic       held_vld;
    logic       held_head;
    logic       in_word;
    logic       lead_word;
    logic [1:0] cls1;
    logic [1:0] cls2;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [1:0] kind_of(input logic [6:0] c);
        if (c >= 7'h61 && c <= 7'h7A) return icc_pkg::CLS_LOWER;
        if (c >= 7'h41 && c <= 7'h5A) return icc_pkg::CLS_UPPER;
        if (c >= 7'h30 && c <= 7'h39) return icc_pkg::CLS_DIGIT;
        return icc_pkg::CLS_OTHER;
    endfunction

    function automatic logic [3:0] style_eff();
        return (style_reg > icc_pkg::STY_PLAIN) ? icc_pkg::STY_PLAIN : style_reg;
    endfunction

    function automatic logic [6:0] joiner(input logic [3:0] st);
        case (st)
            icc_pkg::STY_SNAKE, icc_pkg::STY_CONSTANT: return icc_pkg::CH_UNDERSCORE;
            icc_pkg::STY_KEBAB, icc_pkg::STY_TRAIN:    return icc_pkg::CH_DASH;
            icc_pkg::STY_DOT:                          return icc_pkg::CH_DOT;
            icc_pkg::STY_PATH:                         return icc_pkg::CH_SLASH;
            icc_pkg::STY_CAPITAL, icc_pkg::STY_SENTENCE,
            icc_pkg::STY_PLAIN:                        return icc_pkg::CH_SPACE;
            default:                                   return icc_pkg::CH_NONE;
        endcase
    endfunction

    function automatic logic upper_wanted(input logic [3:0] st, input logic lead,
                                          input logic head);
        case (st)
            icc_pkg::STY_CAMEL:                      return !lead && head;
            icc_pkg::STY_PASCAL, icc_pkg::STY_CAPITAL,
            icc_pkg::STY_TRAIN:                      return head;
            icc_pkg::STY_CONSTANT:                   return 1'b1;
            icc_pkg::STY_SENTENCE:                   return lead && head;
            default:                                 return 1'b0;
        endcase
    endfunction

    task automatic put_char(input logic [6:0] c, inout int n);
        icc_pkg::t_result r;
        r.eos        = 1'b0;
        r.char_valid = 1'b1;
        r.out_char   = c;
        expected_chars.push_back(r);
        n++;
    endtask

    task automatic release_held(inout int n);
        logic [6:0] c;
        logic [1:0] k;
        logic [3:0] st;
        logic       up;
        if (!held_vld) return;
        c  = held_ch;
        k  = kind_of(c);
        st = style_eff();
        if (held_head && !lead_word) begin
            if (joiner(st) != icc_pkg::CH_NONE) put_char(joiner(st), n);
            if ((st == icc_pkg::STY_CAMEL || st == icc_pkg::STY_PASCAL) &&
                k == icc_pkg::CLS_DIGIT) begin
                put_char(icc_pkg::CH_UNDERSCORE, n);
            end
        end
        up = upper_wanted(st, lead_word, held_head);
        if (up && k == icc_pkg::CLS_LOWER) begin
            c = c - icc_pkg::CASE_DELTA;
        end else if (!up && k == icc_pkg::CLS_UPPER) begin
            c = c + icc_pkg::CASE_DELTA;
        end
        put_char(c, n);
        held_vld = 1'b0;
    endtask

    task automatic restart_string();
        held_ch   = 7'd0;
        held_vld  = 1'b0;
        held_head = 1'b0;
        in_word   = 1'b0;
        lead_word = 1'b1;
        cls1      = icc_pkg::CLS_OTHER;
        cls2      = icc_pkg::CLS_OTHER;
    endtask

    task automatic convert_char(input logic [6:0] c, input logic last);
        int               n;
        logic [1:0]       k;
        logic             head;
        icc_pkg::t_result r;
        n = 0;
        k = kind_of(c);
        if (k == icc_pkg::CLS_OTHER) begin
            release_held(n);
            if (in_word) lead_word = 1'b0;
            in_word = 1'b0;
            cls1    = icc_pkg::CLS_OTHER;
            cls2    = icc_pkg::CLS_OTHER;
        end else begin
            if (!in_word) begin
                release_held(n);
                in_word = 1'b1;
                head    = 1'b1;
                cls2    = icc_pkg::CLS_OTHER;
                cls1    = k;
            end else if (cls2 == icc_pkg::CLS_UPPER && cls1 == icc_pkg::CLS_UPPER &&
                         k == icc_pkg::CLS_LOWER) begin
                // split before the last capital of an acronym
                lead_word = 1'b0;
                held_head = 1'b1;
                release_held(n);
                head = 1'b0;
                cls2 = icc_pkg::CLS_UPPER;
                cls1 = icc_pkg::CLS_LOWER;
            end else if ((cls1 == icc_pkg::CLS_LOWER || cls1 == icc_pkg::CLS_DIGIT) &&
                         k == icc_pkg::CLS_UPPER) begin
                release_held(n);
                lead_word = 1'b0;
                head      = 1'b1;
                cls2      = icc_pkg::CLS_OTHER;
                cls1      = icc_pkg::CLS_UPPER;
            end else begin
                release_held(n);
                head = 1'b0;
                cls2 = cls1;
                cls1 = k;
            end
            held_ch   = c;
            held_vld  = 1'b1;
            held_head = head;
        end
        if (last) begin
            release_held(n);
            if (n == 0) begin
                r.eos        = 1'b1;
                r.char_valid = 1'b0;
                r.out_char   = icc_pkg::CH_NONE;
                expected_chars.push_back(r);
            end else begin
                r     = expected_chars.pop_back();
                r.eos = 1'b1;
                expected_chars.push_back(r);
            end
            restart_string();
        end
    endtask

    always @(posedge i_clk) begin
        icc_pkg::t_result want;
        if (!i_rst_n) begin
            style_reg = icc_pkg::STY_CAMEL;
            restart_string();
            expected_chars.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected result: out_char %h char_valid %b end_of_string %b",
                           i_m_tdata[6:0], i_m_tuser, i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    o_checked++;
                    if (i_m_tdata[6:0] !== want.out_char) begin
                        $error("out_char mismatch: expected %h, actual %h",
                               want.out_char, i_m_tdata[6:0]);
                        o_fail_count++;
                    end
                    if (i_m_tuser !== want.char_valid) begin
                        $error("char_valid mismatch: expected %b, actual %b",
                               want.char_valid, i_m_tuser);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== want.eos) begin
                        $error("end_of_string mismatch: expected %b, actual %b",
                               want.eos, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) style_reg = i_cfg_data;
            if (i_s_tvalid && i_s_tready) convert_char(i_s_tdata[6:0], i_s_tlast);
        end
        o_pending = expected_chars.size();
    end

endmodule

// ===== verif/tb_identifier_case_converter.sv =====
// Testbench top for the identifier case converter: clock, reset, character and style stimulus
// with random gaps and stalls, and the final verdict. Depends on icc_pkg, icc_checker and identifier_case_converter.

module tb_identifier_case_converter;

    localparam int         LIMIT        = 200000;
    localparam int         DRAIN        = 8;
    localparam int         PHASES       = 16;
    localparam int         PHASE_ITEMS  = 18;
    localparam logic [3:0] STY_SPARE_LO = 4'd11;
    localparam logic [3:0] STY_SPARE_HI = 4'd15;

    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'd0;
    logic       s_tlast   = 1'b0;
    logic       m_tready  = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [3:0] cfg_data  = 4'd0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_ready;

    int         fails;
    int         pending;
    int         checked;
    int         cycle_count = 0;
    int         rx_mode     = 1;
    int         rx_tick     = 0;
    int         burst_left  = 0;
    int         gaps_on     = 1;
    int         chars_sent  = 0;
    int         strings_sent = 0;
    logic [6:0] text_buf[$];
    logic [3:0] style_plan [0:PHASES-1];

    identifier_case_converter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    icc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("identifier_case_converter test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(99, 0) >= 30);
            2:       m_tready <= ((rx_tick % 7) < 3);
            default: m_tready <= (((rx_tick / 5) % 3) != 0);
        endcase
    end

    function automatic logic [6:0] pick(input int lo, input int hi);
        return 7'($urandom_range(hi, lo));
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_char(input logic [6:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = gaps_on ? $urandom_range(6, 0) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        burst_left--;
        chars_sent++;
        if (last) strings_sent++;
    endtask

    task automatic flush_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(7'(s[i]));
        flush_text();
    endtask

    task automatic wait_idle(input int extra);
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_style(input logic [3:0] st);
        cfg_valid <= 1'b1;
        cfg_data  <= st;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_word();
        int len;
        len = $urandom_range(5, 1);
        case ($urandom_range(5, 0))
            0: repeat (len) text_buf.push_back(pick("a", "z"));
            1: begin
                text_buf.push_back(pick("A", "Z"));
                repeat (len - 1) text_buf.push_back(pick("a", "z"));
            end
            2: repeat ($urandom_range(4, 1)) text_buf.push_back(pick("A", "Z"));
            3: repeat ($urandom_range(3, 1)) text_buf.push_back(pick("0", "9"));
            4: begin
                repeat ($urandom_range(3, 2)) text_buf.push_back(pick("A", "Z"));
                repeat ($urandom_range(3, 1)) text_buf.push_back(pick("a", "z"));
            end
            default: begin
                repeat (len) begin
                    case ($urandom_range(2, 0))
                        0:       text_buf.push_back(pick("a", "z"));
                        1:       text_buf.push_back(pick("A", "Z"));
                        default: text_buf.push_back(pick("0", "9"));
                    endcase
                end
            end
        endcase
    endtask

    task automatic add_gap_chars();
        string seps;
        seps = "_- ./";
        repeat ($urandom_range(2, 1)) begin
            if ($urandom_range(3, 0) == 0) text_buf.push_back(pick(0, 127));
            else text_buf.push_back(7'(seps[$urandom_range(4, 0)]));
        end
    endtask

    task automatic build_string();
        int words;
        if ($urandom_range(9, 0) == 0) begin
            add_gap_chars();
            return;
        end
        if ($urandom_range(4, 0) == 0) add_gap_chars();
        words = $urandom_range(4, 1);
        for (int w = 0; w < words; w++) begin
            if (w > 0 && $urandom_range(2, 0) != 0) add_gap_chars();
            add_word();
            if ($urandom_range(9, 0) == 0) text_buf.push_back(pick(0, 127));
        end
        if ($urandom_range(5, 0) == 0) add_gap_chars();
    endtask

    initial begin
        int phase_start;
        style_plan = '{icc_pkg::STY_CAMEL, icc_pkg::STY_PASCAL, icc_pkg::STY_SNAKE,
                       icc_pkg::STY_KEBAB, icc_pkg::STY_CONSTANT, icc_pkg::STY_DOT,
                       icc_pkg::STY_CAPITAL, icc_pkg::STY_TRAIN, icc_pkg::STY_PATH,
                       icc_pkg::STY_SENTENCE, icc_pkg::STY_PLAIN, STY_SPARE_HI, STY_SPARE_LO,
                       icc_pkg::STY_CAMEL, icc_pkg::STY_SENTENCE, icc_pkg::STY_PASCAL};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // directed strings under the reset style
        send_char(7'h00, 1'b1);
        send_char(7'h7F, 1'b1);
        send_text("z");
        send_text("HTMLFile");
        send_text("a_9b");
        send_text("v2Go");
        send_text("-Ab");
        send_text("Z@");

        for (int p = 0; p < PHASES; p++) begin
            wait_idle(DRAIN);
            write_style(style_plan[p]);
            rx_mode = p % 4;
            gaps_on = (p % 3 != 0);
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_ITEMS) begin
                build_string();
                flush_text();
                if ($urandom_range(5, 0) == 0) wait_idle(0);
            end
        end

        wait_idle(DRAIN);
        $display("Sent %0d characters in %0d strings over %0d style settings, unused codes too.",
                 chars_sent, strings_sent, PHASES);
        $display("Checked %0d results under four receiver stall patterns.", checked);
        if (fails == 0 && pending == 0) begin
            $display("identifier_case_converter test passed");
        end else begin
            $display("identifier_case_converter test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/icc_pkg.sv
rtl/icc_step.sv
rtl/icc_result_queue.sv
rtl/identifier_case_converter.sv
verif/icc_checker.sv
verif/tb_identifier_case_converter.sv
